// ----- sv/uhpc_pkg.sv -----
// Shared types and constants for the USB hub port controller.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package uhpc_pkg;

	localparam int PORT_COUNT = 6;
	localparam int PORT_W     = 3;
	localparam int DEV_W      = 8;
	localparam int CHG_W      = 16;
	localparam int SETTLE_W   = 10;
	localparam int MAP_W      = 8;

	localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10);
	localparam logic [3:0]          STATE_UNKNOWN = 4'd8;

	localparam logic [CHG_W-1:0] CHG_CONNECTION = 16'h0001;
	localparam logic [CHG_W-1:0] CHG_ENABLE     = 16'h0002;
	localparam logic [CHG_W-1:0] CHG_RESET      = 16'h0010;

	// Raw command codes as they arrive on the request channel.
	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_CONNECT    = 3'd1,
		CMD_DISCONNECT = 3'd2,
		CMD_SET        = 3'd3,
		CMD_SET_ALL    = 3'd4,
		CMD_CLEAR      = 3'd5,
		CMD_READ       = 3'd6,
		CMD_SPARE      = 3'd7
	} cmd_t;

	// Operations after classification; the spare code folds into a read.
	typedef enum logic [2:0] {
		OP_TICK,
		OP_CONNECT,
		OP_DISCONNECT,
		OP_SET,
		OP_SET_ALL,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		MODE_UNCONFIGURED = 3'd0,
		MODE_OFF          = 3'd1,
		MODE_DISCONNECTED = 3'd2,
		MODE_DISABLED     = 3'd3,
		MODE_RESETTING    = 3'd4,
		MODE_ENABLED      = 3'd5,
		MODE_SUSPENDED    = 3'd6,
		MODE_RESUMING     = 3'd7
	} mode_t;

	// A classified command as it travels from the front end to the port table.
	typedef struct packed {
		op_t               op;
		logic [PORT_W-1:0] port;
		logic              port_ok;
		mode_t             target_mode;
		logic [CHG_W-1:0]  change_mask;
		logic [DEV_W-1:0]  device_id;
	} item_t;

endpackage

// ----- sv/uhpc_chan_if.sv -----
// Request and response channel interfaces of the USB hub port controller.
// Depends on uhpc_pkg for field widths.
interface uhpc_req_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    command;
	logic [uhpc_pkg::PORT_W-1:0]   port;
	logic [2:0]                    target_mode;
	logic [uhpc_pkg::CHG_W-1:0]    change_mask;
	logic [uhpc_pkg::DEV_W-1:0]    device_id;

	modport source (output valid, command, port, target_mode, change_mask, device_id,
		input ready);
	modport sink (input valid, command, port, target_mode, change_mask, device_id,
		output ready);
endinterface

interface uhpc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [31:0]                   port_status;
	logic [3:0]                    port_state;
	logic [uhpc_pkg::MAP_W-1:0]    change_bitmap;
	logic [uhpc_pkg::PORT_W-1:0]   found_port;
	logic                          failed;

	modport source (output valid, port_status, port_state, change_bitmap, found_port,
		failed, input ready);
	modport sink (input valid, port_status, port_state, change_bitmap, found_port,
		failed, output ready);
endinterface

// ----- sv/uhpc_front.sv -----
// Front end: accepts request transactions and classifies them into items.
// Depends on uhpc_pkg and uhpc_req_if.
module uhpc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	uhpc_req_if.sink             req,
	output logic                 item_valid,
	output uhpc_pkg::item_t      item,
	input  logic                 item_ready
);

	logic            valid_s1;
	uhpc_pkg::item_t item_s1;
	uhpc_pkg::item_t classified;
	logic            take;

	assign req.ready = !valid_s1 || item_ready;
	assign take      = req.valid && req.ready;

	always_comb begin
		classified.port        = req.port;
		classified.port_ok     = (32'(req.port) < uhpc_pkg::PORT_COUNT);
		classified.target_mode = uhpc_pkg::mode_t'(req.target_mode);
		classified.change_mask = req.change_mask;
		classified.device_id   = req.device_id;
		case (uhpc_pkg::cmd_t'(req.command))
			uhpc_pkg::CMD_TICK:       classified.op = uhpc_pkg::OP_TICK;
			uhpc_pkg::CMD_CONNECT:    classified.op = uhpc_pkg::OP_CONNECT;
			uhpc_pkg::CMD_DISCONNECT: classified.op = uhpc_pkg::OP_DISCONNECT;
			uhpc_pkg::CMD_SET:        classified.op = uhpc_pkg::OP_SET;
			uhpc_pkg::CMD_SET_ALL:    classified.op = uhpc_pkg::OP_SET_ALL;
			uhpc_pkg::CMD_CLEAR:      classified.op = uhpc_pkg::OP_CLEAR;
			default:                  classified.op = uhpc_pkg::OP_READ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= classified;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- sv/uhpc_queue.sv -----
// Two-entry queue between the front end and the port table.
// Depends on uhpc_pkg for the item type.
module uhpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  uhpc_pkg::item_t push_item,
	output logic            push_ready,
	output logic            pop_valid,
	output uhpc_pkg::item_t pop_item,
	input  logic            pop_ready
);

	uhpc_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- sv/uhpc_back.sv -----
// Back end: the per-port state table, command execution and the response register.
// Depends on uhpc_pkg and uhpc_rsp_if.
module uhpc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [uhpc_pkg::SETTLE_W-1:0] cfg_wdata,
	input  logic                          item_valid,
	input  uhpc_pkg::item_t               item,
	output logic                          item_ready,
	uhpc_rsp_if.source                    rsp
);

	typedef struct packed {
		uhpc_pkg::mode_t                 mode;
		uhpc_pkg::mode_t                 armed;
		logic                            occupied;
		logic [uhpc_pkg::CHG_W-1:0]      changes;
		logic [uhpc_pkg::SETTLE_W-1:0]   count;
	} port_rec_t;

	port_rec_t                      rec_q   [uhpc_pkg::PORT_COUNT];
	port_rec_t                      rec_n   [uhpc_pkg::PORT_COUNT];
	logic [uhpc_pkg::DEV_W-1:0]     dev_q   [uhpc_pkg::PORT_COUNT];
	logic [uhpc_pkg::PORT_COUNT-1:0] dev_we;
	logic [uhpc_pkg::SETTLE_W-1:0]  settle_q;
	logic [uhpc_pkg::SETTLE_W-1:0]  settle_eff;

	logic                           rsp_valid_q;
	logic [31:0]                    status_q;
	logic [3:0]                     state_q;
	logic [uhpc_pkg::MAP_W-1:0]     bitmap_q;
	logic [uhpc_pkg::PORT_W-1:0]    found_q;
	logic                           failed_q;

	logic [31:0]                    status_n;
	logic [3:0]                     state_n;
	logic [uhpc_pkg::MAP_W-1:0]     bitmap_n;
	logic [uhpc_pkg::PORT_W-1:0]    found_n;
	logic                           failed_n;
	logic                           hit;
	logic                           exec;

	// Port rules for a mode change; the settle count is only touched on arming.
	function automatic port_rec_t apply_state(port_rec_t r, uhpc_pkg::mode_t st,
			logic [uhpc_pkg::SETTLE_W-1:0] settle);
		port_rec_t o;
		o = r;
		case (st)
			uhpc_pkg::MODE_OFF: begin
				o.changes = r.changes & ~(uhpc_pkg::CHG_CONNECTION | uhpc_pkg::CHG_ENABLE
					| uhpc_pkg::CHG_RESET);
			end
			uhpc_pkg::MODE_RESETTING, uhpc_pkg::MODE_RESUMING: begin
				o.count = settle;
				o.armed = st;
			end
			uhpc_pkg::MODE_ENABLED: begin
				if (r.mode == uhpc_pkg::MODE_RESETTING) begin
					o.changes = r.changes | uhpc_pkg::CHG_RESET;
				end
			end
			default: o = o;
		endcase
		o.mode = st;
		return o;
	endfunction

	function automatic logic [31:0] status_word(port_rec_t r);
		logic [31:0] s;
		s      = 32'd0;
		s[0]   = r.occupied;
		s[1]   = (r.mode == uhpc_pkg::MODE_ENABLED);
		s[2]   = (r.mode == uhpc_pkg::MODE_SUSPENDED) || (r.mode == uhpc_pkg::MODE_RESUMING);
		s[4]   = (r.mode == uhpc_pkg::MODE_RESETTING);
		s[8]   = (r.mode != uhpc_pkg::MODE_OFF);
		s[31:16] = r.changes;
		return s;
	endfunction

	assign item_ready = !rsp_valid_q || rsp.ready;
	assign exec       = item_valid && item_ready;
	assign settle_eff = (settle_q == '0) ? uhpc_pkg::SETTLE_W'(1) : settle_q;

	always_comb begin
		hit      = 1'b0;
		found_n  = '0;
		failed_n = 1'b0;
		dev_we   = '0;
		for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
			rec_n[i] = rec_q[i];
		end
		case (item.op)
			uhpc_pkg::OP_TICK: begin
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					if (rec_q[i].count != '0) begin
						rec_n[i].count = rec_q[i].count - uhpc_pkg::SETTLE_W'(1);
						if (rec_q[i].count == uhpc_pkg::SETTLE_W'(1)
								&& rec_q[i].mode == rec_q[i].armed) begin
							rec_n[i] = apply_state(rec_n[i], uhpc_pkg::MODE_ENABLED, settle_eff);
						end
					end
				end
			end
			uhpc_pkg::OP_CONNECT: begin
				failed_n = 1'b1;
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					if (!hit && !rec_q[i].occupied) begin
						hit              = 1'b1;
						rec_n[i].occupied = 1'b1;
						rec_n[i].mode    = uhpc_pkg::MODE_DISABLED;
						rec_n[i].changes = rec_q[i].changes | uhpc_pkg::CHG_CONNECTION;
						dev_we[i]        = 1'b1;
						found_n          = uhpc_pkg::PORT_W'(i);
						failed_n         = 1'b0;
					end
				end
			end
			uhpc_pkg::OP_DISCONNECT: begin
				failed_n = 1'b1;
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					if (!hit && rec_q[i].occupied && dev_q[i] == item.device_id) begin
						hit              = 1'b1;
						rec_n[i].occupied = 1'b0;
						rec_n[i].mode    = uhpc_pkg::MODE_DISCONNECTED;
						rec_n[i].changes = rec_q[i].changes | uhpc_pkg::CHG_CONNECTION;
						found_n          = uhpc_pkg::PORT_W'(i);
						failed_n         = 1'b0;
					end
				end
			end
			uhpc_pkg::OP_SET: begin
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					if (item.port_ok && item.port == uhpc_pkg::PORT_W'(i)) begin
						rec_n[i] = apply_state(rec_q[i], item.target_mode, settle_eff);
					end
				end
			end
			uhpc_pkg::OP_SET_ALL: begin
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					rec_n[i] = apply_state(rec_q[i], item.target_mode, settle_eff);
				end
			end
			uhpc_pkg::OP_CLEAR: begin
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					if (item.port_ok && item.port == uhpc_pkg::PORT_W'(i)) begin
						rec_n[i].changes = rec_q[i].changes & ~item.change_mask;
					end
				end
			end
			default: hit = 1'b0;
		endcase

		// The response reflects the table after the command has been applied.
		bitmap_n = '0;
		status_n = 32'd0;
		state_n  = uhpc_pkg::STATE_UNKNOWN;
		for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
			bitmap_n[i+1] = (rec_n[i].changes != '0);
			if (item.port_ok && item.port == uhpc_pkg::PORT_W'(i)) begin
				status_n = status_word(rec_n[i]);
				state_n  = {1'b0, rec_n[i].mode};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q    <= uhpc_pkg::SETTLE_RESET;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
				rec_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				settle_q <= cfg_wdata;
			end
			if (item_ready) begin
				rsp_valid_q <= item_valid;
			end
			if (exec) begin
				for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
					rec_q[i] <= rec_n[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q <= status_n;
			state_q  <= state_n;
			bitmap_q <= bitmap_n;
			found_q  <= found_n;
			failed_q <= failed_n;
			for (int i = 0; i < uhpc_pkg::PORT_COUNT; i++) begin
				if (dev_we[i]) begin
					dev_q[i] <= item.device_id;
				end
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.port_status   = status_q;
	assign rsp.port_state    = state_q;
	assign rsp.change_bitmap = bitmap_q;
	assign rsp.found_port    = found_q;
	assign rsp.failed        = failed_q;

endmodule

// ----- sv/usb_hub_port_controller.sv -----
// Top level of the USB hub port controller: front end, queue and port table.
// Depends on uhpc_pkg, uhpc_chan_if, uhpc_front, uhpc_queue and uhpc_back.
//
//   Channel  Dir  Handshake    Contents
//   req      in   valid/ready  command, port, target_mode, change_mask, device_id
//   rsp      out  valid/ready  port_status, port_state, change_bitmap, found_port, failed
//   cfg      in   cfg_we only  settle_ticks (10 bits), written on any enabled edge
//
// Every request transaction yields exactly one response transaction, in order.
// The block sustains one transaction per cycle while rsp.ready holds; each response passes
// through the front-end register, the queue slot and the response register after acceptance.
// Reset clears every port to unconfigured with no changes, no devices and no countdown,
// and restores settle_ticks to ten. No clearing pass is needed after reset.
// A stalled response holds the port table; the two-entry queue lets the front end keep
// accepting while the back end waits, and the request side stalls once the queue and front register fill.
module usb_hub_port_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [uhpc_pkg::SETTLE_W-1:0] cfg_wdata,
	uhpc_req_if.sink                      req,
	uhpc_rsp_if.source                    rsp
);

	// Classified items travel from the front end to the queue, then to the table.
	logic            front_valid;
	logic            front_ready;
	uhpc_pkg::item_t front_item;
	logic            back_valid;
	logic            back_ready;
	uhpc_pkg::item_t back_item;

	// The front end decodes the command and checks the port number once, so the
	// back end only sees clean operation codes and a port-valid flag.
	uhpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (front_valid),
		.item       (front_item),
		.item_ready (front_ready)
	);

	uhpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_item  (front_item),
		.push_ready (front_ready),
		.pop_valid  (back_valid),
		.pop_item   (back_item),
		.pop_ready  (back_ready)
	);

	// The back end updates all ports in the cycle the item is popped and registers
	// the response built from the updated table.
	uhpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item_valid (back_valid),
		.item       (back_item),
		.item_ready (back_ready),
		.rsp        (rsp)
	);

endmodule
